@@ src/r_squared_accumulator_unit_assert.svh @@
`ifndef R_SQUARED_ACCUMULATOR_UNIT_ASSERT_SVH
`define R_SQUARED_ACCUMULATOR_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define RSQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define RSQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/rsq_pkg.sv @@
package rsq_pkg;

    localparam int MAX_SAMPLES = 65536;

    localparam int SMP_W  = 16;
    localparam int FRAC_W = 16;
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W  = CNT_W + SMP_W;
    localparam int SQ_W   = CNT_W + 2 * SMP_W - 2;
    localparam int SSE_W  = CNT_W + 2 * SMP_W + 2;
    localparam int DF_W   = CNT_W + 1;
    localparam int K_W    = 8;
    localparam int RES_W  = 32;
    localparam int STAT_W = 2;

    // shift-add product, wide enough for sse * n * (n - 1)
    localparam int PROD_W = SSE_W + 2 * CNT_W;
    // quotient bits kept; anything at or above 2^QB saturates
    localparam int QB     = 34;
    localparam int NUM_W  = PROD_W + FRAC_W + 2;
    localparam int REM_W  = PROD_W + 2;
    localparam int DCNT_W = $clog2(QB + 1);

    localparam int PADDR_W = 3;
    localparam int IDX_W   = PADDR_W - 2;
    localparam int DATA_W  = 32;

    localparam logic [IDX_W-1:0] REG_EXTRA_PARAMS = '0;

    localparam logic [RES_W-1:0] ONE_Q16 = RES_W'(65536);
    localparam logic [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};
    localparam logic [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
    // largest quotient that still fits when subtracted from / added to 1.0
    localparam logic [QB-1:0] LIM_DOWN = QB'(64'd2147549184);
    localparam logic [QB-1:0] LIM_UP   = QB'(64'd2147418111);

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_NO_VAR = 2'd1,
        STAT_NO_DOF = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        SEL_N_SUMSQ,
        SEL_MAG_SQ,
        SEL_NSST_ADF,
        SEL_SSE_N,
        SEL_PROD_NM1
    } t_mul_sel;

    typedef enum logic [3:0] {
        ST_ACC,
        ST_M1,
        ST_M1R,
        ST_M2,
        ST_M2R,
        ST_SUB,
        ST_CHK,
        ST_M3R,
        ST_M4,
        ST_M4R,
        ST_M5,
        ST_M5R,
        ST_DL,
        ST_DR,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic     acc;
        logic     mul_load;
        t_mul_sel mul_sel;
        logic     mul_step;
        logic     save;
        logic     sub;
        logic     div_load;
        logic     div_step;
        logic     finish;
    } t_dp_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic nsst_zero;
        logic df_zero;
        logic out_busy;
    } t_dp_stat;

endpackage

@@ src/rsq_ctrl.sv @@
module rsq_ctrl
    import rsq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_last_sample,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACC;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_ACC: begin
                if (i_in_valid && i_last_sample) begin
                    n_state = ST_M1;
                end
            end
            ST_M1:  n_state = ST_M1R;
            ST_M1R: if (i_stat.mul_done) n_state = ST_M2;
            ST_M2:  n_state = ST_M2R;
            ST_M2R: if (i_stat.mul_done) n_state = ST_SUB;
            ST_SUB: n_state = ST_CHK;
            ST_CHK: begin
                if (i_stat.nsst_zero || i_stat.df_zero) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_M3R;
                end
            end
            ST_M3R: if (i_stat.mul_done) n_state = ST_M4;
            ST_M4:  n_state = ST_M4R;
            ST_M4R: if (i_stat.mul_done) n_state = ST_M5;
            ST_M5:  n_state = ST_M5R;
            ST_M5R: if (i_stat.mul_done) n_state = ST_DL;
            ST_DL:  n_state = ST_DR;
            ST_DR:  if (i_stat.div_done) n_state = ST_FIN;
            ST_FIN: if (!i_stat.out_busy) n_state = ST_ACC;
            default: n_state = ST_ACC;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_ACC: begin
                o_in_ready = 1'b1;
                o_cmd.acc  = i_in_valid;
            end
            ST_M1: begin
                o_cmd.mul_load = 1'b1;
                o_cmd.mul_sel  = SEL_N_SUMSQ;
            end
            ST_M2: begin
                o_cmd.save     = 1'b1;
                o_cmd.mul_load = 1'b1;
                o_cmd.mul_sel  = SEL_MAG_SQ;
            end
            ST_SUB: o_cmd.sub = 1'b1;
            ST_CHK: begin
                o_cmd.mul_load = !(i_stat.nsst_zero || i_stat.df_zero);
                o_cmd.mul_sel  = SEL_NSST_ADF;
            end
            ST_M4: begin
                o_cmd.save     = 1'b1;
                o_cmd.mul_load = 1'b1;
                o_cmd.mul_sel  = SEL_SSE_N;
            end
            ST_M5: begin
                o_cmd.mul_load = 1'b1;
                o_cmd.mul_sel  = SEL_PROD_NM1;
            end
            ST_M1R, ST_M2R, ST_M3R, ST_M4R, ST_M5R: begin
                o_cmd.mul_step = !i_stat.mul_done;
            end
            ST_DL:  o_cmd.div_load = 1'b1;
            ST_DR:  o_cmd.div_step = !i_stat.div_done;
            ST_FIN: o_cmd.finish   = !i_stat.out_busy;
            default: o_cmd = '0;
        endcase
    end

endmodule

@@ src/rsq_datapath.sv @@
module rsq_datapath
    import rsq_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    input  logic [K_W-1:0]          i_extra_parameters,
    input  logic signed [SMP_W-1:0] i_actual_value,
    input  logic signed [SMP_W-1:0] i_predicted_value,
    input  logic                    i_out_ready,
    output t_dp_stat                o_stat,
    output logic                    o_out_valid,
    output logic signed [RES_W-1:0] o_r_squared,
    output logic [STAT_W-1:0]       o_status,
    output logic [CNT_W-1:0]        o_sample_count
);

    // run accumulators
    logic [CNT_W-1:0]        r_cnt;
    logic signed [SUM_W-1:0] r_sum;
    logic [SQ_W-1:0]         r_sumsq;
    logic [SSE_W-1:0]        r_sse;

    logic signed [SMP_W:0]       err;
    logic signed [2*SMP_W-1:0]   sq_act;
    logic signed [2*SMP_W+1:0]   sq_err;

    always_comb begin
        err    = {i_actual_value[SMP_W-1], i_actual_value}
               - {i_predicted_value[SMP_W-1], i_predicted_value};
        sq_act = i_actual_value * i_actual_value;
        sq_err = err * err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.finish) begin
            r_cnt   <= '0;
            r_sum   <= '0;
            r_sumsq <= '0;
            r_sse   <= '0;
        end else if (i_cmd.acc && (r_cnt < CNT_W'(MAX_SAMPLES))) begin
            r_cnt   <= r_cnt + CNT_W'(1);
            r_sum   <= r_sum + {{(SUM_W-SMP_W){i_actual_value[SMP_W-1]}}, i_actual_value};
            r_sumsq <= r_sumsq + SQ_W'($unsigned(sq_act));
            r_sse   <= r_sse + SSE_W'($unsigned(sq_err));
        end
    end

    // degrees of freedom n - (k + 1), kept mod 2^DF_W; sign bit gives direction
    logic [DF_W-1:0]  df;
    logic             df_neg;
    logic [DF_W-1:0]  df_mag;
    logic [SUM_W-1:0] mag;
    logic [CNT_W-1:0] nm1;

    always_comb begin
        df     = {1'b0, r_cnt} - DF_W'(i_extra_parameters) - DF_W'(1);
        df_neg = df[DF_W-1];
        df_mag = df_neg ? (DF_W'(0) - df) : df;
        mag    = r_sum[SUM_W-1] ? (SUM_W'(0) - $unsigned(r_sum)) : $unsigned(r_sum);
        nm1    = r_cnt - CNT_W'(1);
    end

    // shift-add multiplier, one multiplier bit a cycle
    logic [PROD_W-1:0] r_mcand;
    logic [SUM_W-1:0]  r_mplier;
    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] r_a;
    logic [PROD_W-1:0] ld_mcand;
    logic [SUM_W-1:0]  ld_mplier;

    always_comb begin
        case (i_cmd.mul_sel)
            SEL_N_SUMSQ: begin
                ld_mcand  = PROD_W'(r_sumsq);
                ld_mplier = SUM_W'(r_cnt);
            end
            SEL_MAG_SQ: begin
                ld_mcand  = PROD_W'(mag);
                ld_mplier = mag;
            end
            SEL_NSST_ADF: begin
                ld_mcand  = r_a;
                ld_mplier = SUM_W'(df_mag[CNT_W-1:0]);
            end
            SEL_SSE_N: begin
                ld_mcand  = PROD_W'(r_sse);
                ld_mplier = SUM_W'(r_cnt);
            end
            SEL_PROD_NM1: begin
                ld_mcand  = r_prod;
                ld_mplier = SUM_W'(nm1);
            end
            default: begin
                ld_mcand  = '0;
                ld_mplier = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_load) begin
            r_mcand  <= ld_mcand;
            r_mplier <= ld_mplier;
            r_prod   <= '0;
        end else if (i_cmd.mul_step) begin
            r_prod   <= r_prod + (r_mplier[0] ? r_mcand : '0);
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
        end
    end

    // r_a holds n*sum_sq, then n*sst, then the denominator
    always_ff @(posedge i_clk) begin
        if (i_cmd.save) begin
            r_a <= r_prod;
        end else if (i_cmd.sub) begin
            r_a <= r_a - r_prod;
        end
    end

    // restoring divider: (num*2^17 + den) / (2*den), one quotient bit a cycle
    logic [REM_W-1:0]  r_rem;
    logic [QB-1:0]     r_nlow;
    logic [QB-1:0]     r_quo;
    logic              r_ovf;
    logic [DCNT_W-1:0] r_dcnt;
    logic [NUM_W-1:0]  n_full;
    logic [REM_W-1:0]  n_hi;
    logic [REM_W-1:0]  dvs;
    logic [REM_W-1:0]  shifted;
    logic              take;

    always_comb begin
        n_full  = NUM_W'({r_prod, {(FRAC_W+1){1'b0}}}) + NUM_W'(r_a);
        n_hi    = REM_W'(n_full[NUM_W-1:QB]);
        dvs     = REM_W'({r_a, 1'b0});
        shifted = {r_rem[REM_W-2:0], r_nlow[QB-1]};
        take    = shifted >= dvs;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_rem  <= n_hi;
            r_nlow <= n_full[QB-1:0];
            r_quo  <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= take ? (shifted - dvs) : shifted;
            r_nlow <= r_nlow << 1;
            r_quo  <= {r_quo[QB-2:0], take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
            r_ovf  <= 1'b0;
        end else if (i_cmd.div_load) begin
            r_dcnt <= DCNT_W'(QB);
            r_ovf  <= n_hi >= dvs;
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt - DCNT_W'(1);
        end
    end

    // final value, rounding already folded into the quotient
    logic [RES_W-1:0] res;
    t_status          stat;

    always_comb begin
        if (r_a == '0) begin
            stat = STAT_NO_VAR;
            res  = '0;
        end else if (df == '0) begin
            stat = STAT_NO_DOF;
            res  = '0;
        end else if (!df_neg) begin
            stat = STAT_OK;
            res  = (r_ovf || (r_quo > LIM_DOWN)) ? RES_MIN : (ONE_Q16 - RES_W'(r_quo));
        end else begin
            stat = STAT_OK;
            res  = (r_ovf || (r_quo > LIM_UP)) ? RES_MAX : (ONE_Q16 + RES_W'(r_quo));
        end
    end

    // output register
    logic                    r_out_valid;
    logic signed [RES_W-1:0] r_r_squared;
    logic [STAT_W-1:0]       r_status;
    logic [CNT_W-1:0]        r_sample_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_r_squared    <= $signed(res);
            r_status       <= stat;
            r_sample_count <= r_cnt;
        end
    end

    always_comb begin
        o_stat.mul_done  = r_mplier == '0;
        o_stat.div_done  = (r_dcnt == '0) || r_ovf;
        o_stat.nsst_zero = r_a == '0;
        o_stat.df_zero   = df == '0;
        o_stat.out_busy  = r_out_valid && !i_out_ready;
    end

    assign o_out_valid    = r_out_valid;
    assign o_r_squared    = r_r_squared;
    assign o_status       = r_status;
    assign o_sample_count = r_sample_count;

endmodule

@@ src/r_squared_accumulator_unit.sv @@
// Throughput: one sample beat per cycle while a run accumulates.
// Result: formed after the beat marked last by one shift-add multiplier (one
// multiplier bit a cycle, up to five products) and a restoring divider (one
// quotient bit a cycle, up to 34 bits). Input ready stays low until the result
// is valid, and longer while the previous result still waits in the output register.
// Reset (i_rst_n low, synchronous) clears k, the accumulators and the output valid.
module r_squared_accumulator_unit
    import rsq_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [PADDR_W-1:0]      paddr,
    input  logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [SMP_W-1:0] i_actual_value,
    input  logic signed [SMP_W-1:0] i_predicted_value,
    input  logic                    i_last_sample,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [RES_W-1:0] o_r_squared,
    output logic [STAT_W-1:0]       o_status,
    output logic [CNT_W-1:0]        o_sample_count
);

    logic [K_W-1:0]   r_extra_parameters;
    logic [IDX_W-1:0] reg_idx;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_extra_parameters <= '0;
        end else if (wr_en && (reg_idx == REG_EXTRA_PARAMS)) begin
            r_extra_parameters <= pwdata[K_W-1:0];
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_EXTRA_PARAMS: prdata = DATA_W'(r_extra_parameters);
            default:          prdata = '0;
        endcase
    end

    t_dp_cmd  cmd;
    t_dp_stat stat;

    rsq_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_last_sample (i_last_sample),
        .i_stat        (stat),
        .o_in_ready    (o_in_ready),
        .o_cmd         (cmd)
    );

    rsq_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_extra_parameters (r_extra_parameters),
        .i_actual_value     (i_actual_value),
        .i_predicted_value  (i_predicted_value),
        .i_out_ready        (i_out_ready),
        .o_stat             (stat),
        .o_out_valid        (o_out_valid),
        .o_r_squared        (o_r_squared),
        .o_status           (o_status),
        .o_sample_count     (o_sample_count)
    );

endmodule

@@ src/rsq_checker.sv @@
`include "r_squared_accumulator_unit_assert.svh"

module rsq_checker
    import rsq_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_ready,
    input logic                    i_last_sample,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input logic signed [RES_W-1:0] o_r_squared,
    input logic [STAT_W-1:0]       o_status,
    input logic [CNT_W-1:0]        o_sample_count
);

    // a stalled result beat holds
    `RSQ_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_r_squared) && $stable(o_status) && $stable(o_sample_count), "result beat changed while stalled")

    // the last beat of a run starts the final computation
    `RSQ_ASSERT_NXT(a_last_stalls, i_in_valid && o_in_ready && i_last_sample, !o_in_ready, "input still ready after last beat")

    // a flagged result carries zero
    `RSQ_ASSERT_IMP(a_flag_zero, o_out_valid && (o_status != STAT_OK), o_r_squared == '0, "flagged result not zero")

    // every run holds at least one pair
    `RSQ_ASSERT_IMP(a_count_nonzero, o_out_valid, o_sample_count != '0, "result with empty run")

endmodule

bind r_squared_accumulator_unit rsq_checker u_rsq_checker (.*);
